>>> rtl/lmtc_pkg.sv
package lmtc_pkg;

   localparam int DOT_W = 9;
   localparam int LINE_W = 8;
   localparam int COL_W = 8;
   localparam int MODE_W = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [DOT_W-1:0]  SEARCH_DOTS   = 9'd80;
   localparam logic [DOT_W-1:0]  TRANSFER_DOTS = 9'd172;
   localparam logic [DOT_W-1:0]  HBLANK_DOTS   = 9'd204;
   localparam logic [DOT_W-1:0]  LINE_DOTS     = SEARCH_DOTS + TRANSFER_DOTS + HBLANK_DOTS;
   localparam logic [COL_W-1:0]  VISIBLE_WIDTH = 8'd160;
   localparam logic [LINE_W-1:0] VISIBLE_LINES = 8'd144;
   localparam logic [LINE_W-1:0] TOTAL_LINES   = 8'd154;

   localparam logic [7:0] STATUS_OFF = 8'h80;

   localparam logic [MODE_W-1:0] PH_HBLANK   = 2'd0;
   localparam logic [MODE_W-1:0] PH_VBLANK   = 2'd1;
   localparam logic [MODE_W-1:0] PH_SEARCH   = 2'd2;
   localparam logic [MODE_W-1:0] PH_TRANSFER = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_LCD_ENABLE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DOUBLE_SPEED = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COMPARE_LINE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_IRQ_HBLANK   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_IRQ_VBLANK   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_IRQ_SEARCH   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_IRQ_MATCH    = 3'd6;

   typedef struct packed {
      logic              lcd_enable;
      logic              double_speed;
      logic [LINE_W-1:0] compare_line;
      logic              irq_hblank_enable;
      logic              irq_vblank_enable;
      logic              irq_search_enable;
      logic              irq_match_enable;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [LINE_W-1:0] line;
      logic              line_match;
      logic              pixel_strobe;
      logic [COL_W-1:0]  pixel_x;
      logic              stat_irq;
      logic              vblank_irq;
      logic              hblank_start;
      logic [7:0]        status_byte;
   } result_type;

endpackage

>>> rtl/lmtc_channels.sv
interface lmtc_req_if;
   import lmtc_pkg::*;

   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink (input valid, input tick, output ready);
endinterface

interface lmtc_rsp_if;
   import lmtc_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [LINE_W-1:0] line;
   logic              line_match;
   logic              pixel_strobe;
   logic [COL_W-1:0]  pixel_x;
   logic              stat_irq;
   logic              vblank_irq;
   logic              hblank_start;
   logic [7:0]        status_byte;

   modport source (output valid, output mode, output line, output line_match,
                   output pixel_strobe, output pixel_x, output stat_irq,
                   output vblank_irq, output hblank_start, output status_byte,
                   input ready);
   modport sink (input valid, input mode, input line, input line_match,
                 input pixel_strobe, input pixel_x, input stat_irq,
                 input vblank_irq, input hblank_start, input status_byte,
                 output ready);
endinterface

>>> rtl/lmtc_csr.sv
module lmtc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lmtc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lmtc_pkg::CSR_DATA_W-1:0]     csr_data,
   output lmtc_pkg::cfg_type                   cfg,
   output logic                                clear_state
);
   import lmtc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_LCD_ENABLE:   cfg_in.lcd_enable = csr_data[0];
            REG_DOUBLE_SPEED: cfg_in.double_speed = csr_data[0];
            REG_COMPARE_LINE: cfg_in.compare_line = csr_data[LINE_W-1:0];
            REG_IRQ_HBLANK:   cfg_in.irq_hblank_enable = csr_data[0];
            REG_IRQ_VBLANK:   cfg_in.irq_vblank_enable = csr_data[0];
            REG_IRQ_SEARCH:   cfg_in.irq_search_enable = csr_data[0];
            REG_IRQ_MATCH:    cfg_in.irq_match_enable = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Turning the display off puts the sequencer back to its reset state at once.
   assign clear_state = csr_we && (csr_index == REG_LCD_ENABLE) && !csr_data[0];
   assign cfg = cfg_ff;

endmodule

>>> rtl/lmtc_seq.sv
module lmtc_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  lmtc_pkg::cfg_type    cfg,
   input  logic                 clear_state,
   input  logic                 step,
   input  logic                 tick,
   output lmtc_pkg::result_type result
);
   import lmtc_pkg::*;

   logic [MODE_W-1:0] phase_ff, phase_in;
   logic [DOT_W-1:0]  dot_ff, dot_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic              toggle_ff, toggle_in;

   logic [DOT_W-1:0]  dot_inc;
   logic [LINE_W-1:0] line_inc;
   logic              advance;
   logic              new_line;
   logic              match;
   logic              strobe;
   logic [COL_W-1:0]  px;
   logic              stat;
   logic              vbl;
   logic              hbs;

   assign dot_inc = dot_ff + 1'b1;
   assign line_inc = line_ff + 1'b1;

   always_comb begin
      phase_in = phase_ff;
      dot_in = dot_ff;
      line_in = line_ff;
      column_in = column_ff;
      toggle_in = toggle_ff;
      advance = 1'b0;
      new_line = 1'b0;
      strobe = 1'b0;
      px = '0;
      stat = 1'b0;
      vbl = 1'b0;
      hbs = 1'b0;

      if (cfg.lcd_enable && tick) begin
         if (cfg.double_speed) begin
            // At double speed only every second dot moves the sequencer.
            advance = toggle_ff;
            toggle_in = ~toggle_ff;
         end else begin
            advance = 1'b1;
         end
      end

      if (advance) begin
         dot_in = dot_inc;
         case (phase_ff)
            PH_SEARCH: begin
               if (dot_inc >= SEARCH_DOTS) begin
                  phase_in = PH_TRANSFER;
                  dot_in = '0;
               end
            end
            PH_TRANSFER: begin
               if (column_ff < VISIBLE_WIDTH) begin
                  strobe = 1'b1;
                  px = column_ff;
                  column_in = column_ff + 1'b1;
               end
               if (dot_inc >= TRANSFER_DOTS) begin
                  phase_in = PH_HBLANK;
                  dot_in = '0;
                  hbs = 1'b1;
                  stat = cfg.irq_hblank_enable;
               end
            end
            PH_HBLANK: begin
               if (dot_inc >= HBLANK_DOTS) begin
                  dot_in = '0;
                  line_in = line_inc;
                  new_line = 1'b1;
                  if (line_inc >= VISIBLE_LINES) begin
                     phase_in = PH_VBLANK;
                     vbl = 1'b1;
                     stat = cfg.irq_vblank_enable;
                  end else begin
                     phase_in = PH_SEARCH;
                     column_in = '0;
                     stat = cfg.irq_search_enable;
                  end
               end
            end
            default: begin
               if (dot_inc >= LINE_DOTS) begin
                  dot_in = '0;
                  line_in = line_inc;
                  new_line = 1'b1;
                  // The frame wraps after the last line, or when the line count rolls over.
                  if (line_inc >= TOTAL_LINES || line_inc == '0) begin
                     phase_in = PH_SEARCH;
                     column_in = '0;
                     line_in = '0;
                     stat = cfg.irq_search_enable;
                  end
               end
            end
         endcase
         if (new_line && line_in == cfg.compare_line && cfg.irq_match_enable) begin
            stat = 1'b1;
         end
      end

      if (!cfg.lcd_enable) begin
         phase_in = PH_SEARCH;
         dot_in = '0;
         line_in = '0;
         column_in = '0;
         toggle_in = 1'b0;
      end
   end

   assign match = cfg.lcd_enable && (line_in == cfg.compare_line);

   always_comb begin
      result.mode = phase_in;
      result.line = line_in;
      result.line_match = match;
      result.pixel_strobe = strobe;
      result.pixel_x = px;
      result.stat_irq = stat;
      result.vblank_irq = vbl;
      result.hblank_start = hbs;
      if (cfg.lcd_enable) begin
         result.status_byte = {1'b1, cfg.irq_match_enable, cfg.irq_search_enable,
                               cfg.irq_vblank_enable, cfg.irq_hblank_enable,
                               match, phase_in};
      end else begin
         result.status_byte = STATUS_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_state) begin
         phase_ff <= PH_SEARCH;
         dot_ff <= '0;
         line_ff <= '0;
         column_ff <= '0;
         toggle_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         dot_ff <= dot_in;
         line_ff <= line_in;
         column_ff <= column_in;
         toggle_ff <= toggle_in;
      end
   end

   a_state_holds_without_step: assert property (
      @(posedge clock) disable iff (reset)
      !step && !clear_state |=> $stable(phase_ff) && $stable(dot_ff) && $stable(line_ff))
      else $error("sequencer state changed without an accepted beat");

   a_line_in_range: assert property (
      @(posedge clock) disable iff (reset)
      line_ff < TOTAL_LINES)
      else $error("line counter passed the last line of the frame");

   a_off_holds_reset: assert property (
      @(posedge clock) disable iff (reset)
      !cfg.lcd_enable |-> phase_ff == PH_SEARCH && dot_ff == '0 && line_ff == '0)
      else $error("sequencer left its reset state while the display is off");

endmodule

>>> rtl/lcd_mode_timing_controller.sv
// A beat is held in the input register until the sequencer steps it into the output
// register, and its result shows on the rsp channel from the output register.
// Throughput: one beat per cycle; an input register and an output register let the
// sequencer step on every cycle in which the output register can be refilled.
// Reset (synchronous, active high) clears the valid flags, the configuration and the
// sequencer: display off, sequencer in OAM search on line 0, no beats held.
module lcd_mode_timing_controller (
   input  logic                              clock,
   input  logic                              reset,
   lmtc_req_if.sink                          req_ch,
   lmtc_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [lmtc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lmtc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import lmtc_pkg::*;

   cfg_type    cfg;
   logic       clear_state;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       in_tick_ff, in_tick_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       out_free;
   logic       step;
   logic       req_fire;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign step = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_fire = req_ch.valid && req_ch.ready;

   lmtc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cfg         (cfg),
      .clear_state (clear_state)
   );

   lmtc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .clear_state (clear_state),
      .step        (step),
      .tick        (in_tick_ff),
      .result      (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_tick_in = in_tick_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_tick_in = req_ch.tick;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_in = result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_tick_ff <= in_tick_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.mode = rsp_ff.mode;
   assign rsp_ch.line = rsp_ff.line;
   assign rsp_ch.line_match = rsp_ff.line_match;
   assign rsp_ch.pixel_strobe = rsp_ff.pixel_strobe;
   assign rsp_ch.pixel_x = rsp_ff.pixel_x;
   assign rsp_ch.stat_irq = rsp_ff.stat_irq;
   assign rsp_ch.vblank_irq = rsp_ff.vblank_irq;
   assign rsp_ch.hblank_start = rsp_ff.hblank_start;
   assign rsp_ch.status_byte = rsp_ff.status_byte;

   a_hblank_pulse_mode: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.hblank_start |-> rsp_ff.mode == PH_HBLANK)
      else $error("h-blank start beat does not report h-blank mode");

   a_vblank_pulse_mode: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.vblank_irq |-> rsp_ff.mode == PH_VBLANK &&
                                            rsp_ff.line == VISIBLE_LINES)
      else $error("v-blank interrupt beat is not on the first v-blank line");

   a_step_fills_output: assert property (
      @(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("a stepped beat did not reach the output register");

endmodule

>>> tb/tb_lcd_mode_timing_controller.sv
`timescale 1ns / 100ps

import lmtc_pkg::*;

// Tracks the dot sequencer and holds the status beats it predicts, oldest first.
class lcd_timing_checker;
   cfg_type           cfg;
   logic [MODE_W-1:0] phase;
   logic [DOT_W-1:0]  dots;
   logic [LINE_W-1:0] line;
   logic [COL_W-1:0]  column;
   logic              half_toggle;
   result_type        expected_status[$];
   int                errors;

   function new();
      cfg = '0;
      errors = 0;
      clear_sequencer();
   endfunction

   function void clear_sequencer();
      phase = PH_SEARCH;
      dots = '0;
      line = '0;
      column = '0;
      half_toggle = 1'b0;
   endfunction

   function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_LCD_ENABLE: begin
            cfg.lcd_enable = data[0];
            if (!data[0]) clear_sequencer();
         end
         REG_DOUBLE_SPEED: cfg.double_speed = data[0];
         REG_COMPARE_LINE: cfg.compare_line = data;
         REG_IRQ_HBLANK:   cfg.irq_hblank_enable = data[0];
         REG_IRQ_VBLANK:   cfg.irq_vblank_enable = data[0];
         REG_IRQ_SEARCH:   cfg.irq_search_enable = data[0];
         REG_IRQ_MATCH:    cfg.irq_match_enable = data[0];
         default: ;
      endcase
   endfunction

   function void note_tick(logic tick);
      result_type want;
      logic       advance;
      logic       new_line;
      want = '0;
      advance = 1'b0;
      new_line = 1'b0;
      if (!cfg.lcd_enable) begin
         clear_sequencer();
      end else if (tick) begin
         if (cfg.double_speed) begin
            advance = half_toggle;
            half_toggle = ~half_toggle;
         end else begin
            advance = 1'b1;
         end
      end

      if (advance) begin
         dots = dots + 1'b1;
         case (phase)
            PH_SEARCH: begin
               if (dots >= SEARCH_DOTS) begin
                  phase = PH_TRANSFER;
                  dots = '0;
               end
            end
            PH_TRANSFER: begin
               if (column < VISIBLE_WIDTH) begin
                  want.pixel_strobe = 1'b1;
                  want.pixel_x = column;
                  column = column + 1'b1;
               end
               if (dots >= TRANSFER_DOTS) begin
                  phase = PH_HBLANK;
                  dots = '0;
                  want.hblank_start = 1'b1;
                  if (cfg.irq_hblank_enable) want.stat_irq = 1'b1;
               end
            end
            PH_HBLANK: begin
               if (dots >= HBLANK_DOTS) begin
                  dots = '0;
                  line = line + 1'b1;
                  new_line = 1'b1;
                  if (line >= VISIBLE_LINES) begin
                     phase = PH_VBLANK;
                     want.vblank_irq = 1'b1;
                     if (cfg.irq_vblank_enable) want.stat_irq = 1'b1;
                  end else begin
                     phase = PH_SEARCH;
                     column = '0;
                     if (cfg.irq_search_enable) want.stat_irq = 1'b1;
                  end
               end
            end
            default: begin
               // V-blank lines are as long as visible ones; the frame wraps back to line 0.
               if (dots >= LINE_DOTS) begin
                  dots = '0;
                  line = line + 1'b1;
                  new_line = 1'b1;
                  if (line >= TOTAL_LINES || line == '0) begin
                     phase = PH_SEARCH;
                     column = '0;
                     line = '0;
                     if (cfg.irq_search_enable) want.stat_irq = 1'b1;
                  end
               end
            end
         endcase
         if (new_line && line == cfg.compare_line && cfg.irq_match_enable)
            want.stat_irq = 1'b1;
      end

      want.mode = phase;
      want.line = line;
      want.line_match = cfg.lcd_enable && (line == cfg.compare_line);
      if (cfg.lcd_enable)
         want.status_byte = STATUS_OFF | {1'b0, cfg.irq_match_enable, cfg.irq_search_enable,
                                          cfg.irq_vblank_enable, cfg.irq_hblank_enable,
                                          want.line_match, phase};
      else
         want.status_byte = STATUS_OFF;
      expected_status.push_back(want);
   endfunction

   function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
   endfunction

   function void check_status(result_type got);
      result_type want;
      if (expected_status.size() == 0) begin
         errors++;
         $display("%0t: status beat arrived with nothing expected, actual 0x%0h", $time, got);
         return;
      end
      want = expected_status.pop_front();
      compare_field("mode", want.mode, got.mode);
      compare_field("line", want.line, got.line);
      compare_field("line_match", want.line_match, got.line_match);
      compare_field("pixel_strobe", want.pixel_strobe, got.pixel_strobe);
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("stat_irq", want.stat_irq, got.stat_irq);
      compare_field("vblank_irq", want.vblank_irq, got.vblank_irq);
      compare_field("hblank_start", want.hblank_start, got.hblank_start);
      compare_field("status_byte", want.status_byte, got.status_byte);
   endfunction
endclass

module tb_lcd_mode_timing_controller;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam int RANDOM_BEATS = 1450;
   localparam int CYCLE_LIMIT = 20_000_000;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   lmtc_req_if req_ch ();
   lmtc_rsp_if rsp_ch ();

   lcd_timing_checker timing_check;
   int                sent_beats;
   int                random_beats;
   int                cycle_count = 0;
   logic              calm_sender;

   lcd_mode_timing_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("lcd_mode_timing_controller verification failed");
         $finish;
      end
   end

   // Status beats are sampled as they stood just before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         timing_check.check_status({rsp_ch.mode, rsp_ch.line, rsp_ch.line_match,
                                    rsp_ch.pixel_strobe, rsp_ch.pixel_x, rsp_ch.stat_irq,
                                    rsp_ch.vblank_irq, rsp_ch.hblank_start,
                                    rsp_ch.status_byte});
   end

   // Receiver backpressure changes character over random spans, from none to heavy.
   initial begin : rsp_backpressure
      int stall_left;
      int stall_pct;
      int span_left;
      stall_left = 0;
      stall_pct = 0;
      span_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (span_left == 0) begin
            span_left = $urandom_range(100, 600);
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 10;
               default: stall_pct = 40;
            endcase
         end
         span_left--;
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            rsp_ch.ready <= 1'b0;
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic sender_pause();
      int gap;
      int roll;
      if (sent_beats % 256 == 0) calm_sender = ($urandom_range(0, 2) == 0);
      roll = $urandom_range(0, 999);
      if (calm_sender || roll < 850) gap = 0;
      else if (roll < 990) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_beat(input logic tick);
      req_ch.valid <= 1'b1;
      req_ch.tick <= tick;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      timing_check.note_tick(tick);
      sent_beats++;
      sender_pause();
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (timing_check.expected_status.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      timing_check.write_reg(index, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // One-bit registers get random upper data bits, which the block must drop.
   task automatic write_flag(input logic [CSR_INDEX_W-1:0] index, input logic value);
      write_csr(index, {7'($urandom), value});
   endtask

   task automatic write_irq_enables(input logic [3:0] enables);
      write_flag(REG_IRQ_HBLANK, enables[0]);
      write_flag(REG_IRQ_VBLANK, enables[1]);
      write_flag(REG_IRQ_SEARCH, enables[2]);
      write_flag(REG_IRQ_MATCH, enables[3]);
   endtask

   task automatic run_to_line(input logic [LINE_W-1:0] target);
      while (timing_check.line != target) send_beat($urandom_range(0, 19) != 0);
   endtask

   task automatic pick_random_settings();
      logic [7:0] compare;
      int         lcd_roll;
      case ($urandom_range(0, 3))
         0: compare = 8'd0;
         1: compare = 8'hFF;
         2: compare = 8'd1;
         default: compare = 8'($urandom);
      endcase
      write_flag(REG_DOUBLE_SPEED, 1'($urandom_range(0, 1)));
      write_csr(REG_COMPARE_LINE, compare);
      write_irq_enables(4'($urandom));
      if ($urandom_range(0, 4) == 0) write_csr(REG_UNUSED, 8'($urandom));
      lcd_roll = $urandom_range(0, 9);
      if (lcd_roll < 3) begin
         write_flag(REG_LCD_ENABLE, 1'b0);
         write_flag(REG_LCD_ENABLE, 1'b1);
      end else if (lcd_roll == 3) begin
         write_flag(REG_LCD_ENABLE, 1'b0);
      end else begin
         write_flag(REG_LCD_ENABLE, 1'b1);
      end
   endtask

   initial begin : stimulus
      int count;
      timing_check = new();
      sent_beats = 0;
      random_beats = 0;
      calm_sender = 1'b0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.tick <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Display still off after reset: sequencer pinned, status reads the off value.
      send_beat(1'b1);
      send_beat(1'b0);
      wait_drained();
      write_csr(REG_UNUSED, 8'hFF);
      write_irq_enables(4'hF);
      write_flag(REG_LCD_ENABLE, 1'b1);
      send_beat(1'b0);
      send_beat(1'b1);
      send_beat(1'b1);
      send_beat(1'b1);
      wait_drained();
      write_flag(REG_DOUBLE_SPEED, 1'b1);
      send_beat(1'b1);
      send_beat(1'b1);
      send_beat(1'b0);
      send_beat(1'b1);
      send_beat(1'b1);
      wait_drained();
      write_csr(REG_COMPARE_LINE, 8'hFF);
      send_beat(1'b1);
      wait_drained();
      write_flag(REG_LCD_ENABLE, 1'b0);
      send_beat(1'b1);
      send_beat(1'b0);
      wait_drained();
      write_flag(REG_LCD_ENABLE, 1'b1);
      write_flag(REG_DOUBLE_SPEED, 1'b0);
      write_csr(REG_COMPARE_LINE, 8'h00);
      send_beat(1'b1);
      send_beat(1'b1);

      // Whole frames: visible lines into v-blank, matches inside v-blank, then the wrap.
      wait_drained();
      write_csr(REG_COMPARE_LINE, 8'($urandom_range(1, 143)));
      write_flag(REG_LCD_ENABLE, 1'b0);
      write_flag(REG_LCD_ENABLE, 1'b1);
      run_to_line(8'd150);
      wait_drained();
      write_csr(REG_COMPARE_LINE, 8'd153);
      write_irq_enables(4'b1010);
      run_to_line(8'd153);
      wait_drained();
      write_csr(REG_COMPARE_LINE, 8'd0);
      write_irq_enables(4'b1000);
      run_to_line(8'd0);
      run_to_line(8'd2);
      wait_drained();
      write_flag(REG_DOUBLE_SPEED, 1'b1);
      write_irq_enables(4'hF);
      repeat (1500) send_beat($urandom_range(0, 19) != 0);

      while (random_beats < RANDOM_BEATS) begin
         wait_drained();
         pick_random_settings();
         count = $urandom_range(40, 250);
         repeat (count) begin
            send_beat($urandom_range(0, 99) < 85);
            random_beats++;
            if ($urandom_range(0, 199) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (timing_check.errors == 0) begin
         $display("lcd_mode_timing_controller verification clean");
      end else begin
         $display("lcd_mode_timing_controller verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/lmtc_pkg.sv
rtl/lmtc_channels.sv
rtl/lmtc_csr.sv
rtl/lmtc_seq.sv
rtl/lcd_mode_timing_controller.sv
tb/tb_lcd_mode_timing_controller.sv
